>>> rtl/ps2dbt_pkg.sv
// Shared types and constants for the PS/2 device byte transmitter.
package ps2dbt_pkg;

   localparam int FIFO_DEPTH = 16;
   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int BYTE_W = 8;
   localparam int BIT_CNT_W = 4;
   localparam int DATA_LAST_BIT = 8;
   localparam int PARITY_BIT = 9;
   localparam int FRAME_LAST_BIT = 11;

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [BYTE_W-1:0] byte_type;

   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_PUSH = 1'b1
   } command_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

endpackage

>>> rtl/ps2dbt_fifo.sv
// Ring FIFO of scan-code bytes, holds at most FIFO_DEPTH-1 entries.
module ps2dbt_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  ps2dbt_pkg::byte_type        push_data,
   input  logic                        pop,
   output ps2dbt_pkg::byte_type        pop_data,
   output ps2dbt_pkg::fifo_status_type status
);
   import ps2dbt_pkg::*;

   byte_type store_ff [FIFO_DEPTH];
   ptr_type  wr_ptr_ff;
   ptr_type  wr_ptr_in;
   ptr_type  rd_ptr_ff;
   ptr_type  rd_ptr_in;

   function automatic ptr_type next_ptr(input ptr_type p);
      ptr_type n;
      if (p == PTR_W'(FIFO_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

   always_comb begin
      status.empty = (wr_ptr_ff == rd_ptr_ff);
      status.full  = (next_ptr(wr_ptr_ff) == rd_ptr_ff);
      pop_data     = store_ff[rd_ptr_ff];
      wr_ptr_in    = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in    = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

endmodule

>>> rtl/ps2_device_byte_transmitter_top.sv
// PS/2 device-to-host byte transmitter: scan-code FIFO and frame sequencer.
//
//   channel | dir | tdata (low bit first)                              | tuser
//   req     | in  | scan_code[7:0]                                     | command
//   rsp     | out | clock_line, data_line, push_accepted, sending, 0s  | -
//
// One item per clock: each push or tick updates the FIFO pointers and the
// frame sequencer in the accepting cycle; the result is held in the state
// registers plus one flag until taken. req_tready drops only while a result
// waits and rsp_tready is low. Reset is synchronous; the FIFO store itself
// is not cleared.
module ps2_device_byte_transmitter_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // scan_code[7:0]
   input  logic [0:0] req_tuser,   // command
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // clock_line, data_line, push_accepted, sending, zeros
);
   import ps2dbt_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_DATA,
      PH_CLK_LOW,
      PH_CLK_HIGH
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [BIT_CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [BIT_CNT_W-1:0]  bit_cnt_inc;
   logic [2:0]            bit_idx;
   byte_type              byte_ff, byte_in;
   logic                  parity_ff, parity_in;
   logic                  clock_level_ff, clock_level_in;
   logic                  data_level_ff, data_level_in;
   logic                  push_acc_ff, push_acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept;
   logic                  is_push;
   logic                  fifo_push;
   logic                  fifo_pop;
   logic                  data_bit;
   byte_type              fifo_data;
   fifo_status_type       fifo_status;

   ps2dbt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (req_tdata),
      .pop       (fifo_pop),
      .pop_data  (fifo_data),
      .status    (fifo_status)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_push    = (command_type'(req_tuser[0]) == CMD_PUSH);
   assign fifo_push  = accept && is_push && !fifo_status.full;
   assign fifo_pop   = accept && !is_push && (phase_ff == PH_IDLE) && !fifo_status.empty;

   assign bit_cnt_inc = bit_cnt_ff + 1'b1;
   assign bit_idx     = 3'(bit_cnt_ff - 1'b1);

   always_comb begin
      phase_in       = phase_ff;
      bit_cnt_in     = bit_cnt_ff;
      byte_in        = byte_ff;
      parity_in      = parity_ff;
      clock_level_in = clock_level_ff;
      data_level_in  = data_level_ff;
      data_bit       = 1'b1;
      push_acc_in    = accept ? fifo_push : push_acc_ff;
      rsp_valid_in   = accept ? 1'b1 : (rsp_valid_ff && !rsp_tready);

      priority if (bit_cnt_ff == '0) begin
         data_bit = 1'b0;
      end else if (bit_cnt_ff <= BIT_CNT_W'(DATA_LAST_BIT)) begin
         data_bit = byte_ff[bit_idx];
      end else if (bit_cnt_ff == BIT_CNT_W'(PARITY_BIT)) begin
         data_bit = !parity_ff;
      end else begin
         data_bit = 1'b1;
      end

      if (accept && !is_push) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (!fifo_status.empty) begin
                  byte_in  = fifo_data;
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               data_level_in = data_bit;
               parity_in     = (bit_cnt_ff == '0) ? 1'b0 : (parity_ff ^ data_bit);
               if (bit_cnt_inc > BIT_CNT_W'(FRAME_LAST_BIT)) begin
                  bit_cnt_in = '0;
                  phase_in   = PH_IDLE;
               end else begin
                  bit_cnt_in = bit_cnt_inc;
                  phase_in   = PH_CLK_LOW;
               end
            end
            PH_CLK_LOW: begin
               clock_level_in = 1'b0;
               phase_in       = PH_CLK_HIGH;
            end
            PH_CLK_HIGH: begin
               clock_level_in = 1'b1;
               phase_in       = PH_DATA;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_cnt_ff     <= '0;
         byte_ff        <= '0;
         parity_ff      <= 1'b0;
         clock_level_ff <= 1'b1;
         data_level_ff  <= 1'b1;
         push_acc_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         bit_cnt_ff     <= bit_cnt_in;
         byte_ff        <= byte_in;
         parity_ff      <= parity_in;
         clock_level_ff <= clock_level_in;
         data_level_ff  <= data_level_in;
         push_acc_ff    <= push_acc_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, (phase_ff != PH_IDLE), push_acc_ff,
                        data_level_ff, clock_level_ff};

   // clock line is low only between the low and high half of a pulse
   assert property (@(posedge clock) disable iff (reset)
      !clock_level_ff |-> (phase_ff == PH_CLK_HIGH))
      else $error("clock line low outside clock pulse");

   // a tick never reports a stored push
   assert property (@(posedge clock) disable iff (reset)
      (accept && !is_push) |=> !push_acc_ff)
      else $error("push_accepted set by a tick");

   // bit counter stays within the frame and is clear while idle
   assert property (@(posedge clock) disable iff (reset)
      (bit_cnt_ff <= BIT_CNT_W'(FRAME_LAST_BIT)) &&
      ((phase_ff != PH_IDLE) || (bit_cnt_ff == '0)))
      else $error("bit counter out of frame");

   // a frame starts only from a non-empty FIFO
   assert property (@(posedge clock) disable iff (reset)
      fifo_pop |-> !fifo_status.empty)
      else $error("FIFO read while empty");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the PS/2 device byte transmitter: directed table, then random.
module tb_top;
   import ps2dbt_pkg::*;

   localparam int RANDOM_ITEMS    = 1200;
   localparam int IDLE_PCT        = 28;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int MAX_REPORTS     = 10;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_DATA,
      SEQ_CLK_LOW,
      SEQ_CLK_HIGH
   } seq_phase_type;

   // bit 0 first: clock_line, data_line, push_accepted, sending
   typedef struct packed {
      logic sending;
      logic push_accepted;
      logic data_line;
      logic clock_line;
   } line_rsp_type;

   typedef struct packed {
      command_type  cmd;
      byte_type     code;
      logic         typed;
      line_rsp_type rsp;
   } stim_row_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic [0:0] req_tuser;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;

   ps2_device_byte_transmitter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // predictor state
   byte_type               line_fifo [FIFO_DEPTH];
   ptr_type                wr_ptr     = '0;
   ptr_type                rd_ptr     = '0;
   seq_phase_type          seq        = SEQ_IDLE;
   logic [BIT_CNT_W-1:0]   bit_idx    = '0;
   byte_type               shift_byte = '0;
   logic                   par_acc    = 1'b0;
   logic                   clk_lvl    = 1'b1;
   logic                   dat_lvl    = 1'b1;

   line_rsp_type expected_lines_q [$];
   stim_row_type directed_rows [$];
   line_rsp_type line_exp;

   int  items_sent     = 0;
   int  bytes_queued   = 0;
   int  pushes_refused = 0;
   int  frames_started = 0;
   int  lines_checked  = 0;
   int  mismatches     = 0;
   int  stall_cycles   = 0;
   bit  no_idle        = 1'b0;
   bit  hold_off_req   = 1'b0;

   function automatic ptr_type ptr_next(ptr_type p);
      return (p == ptr_type'(FIFO_DEPTH - 1)) ? '0 : ptr_type'(p + 1'b1);
   endfunction

   task automatic ps2_line_predict(input command_type cmd, input byte_type code,
                                   output line_rsp_type r);
      logic    acc;
      logic    d;
      ptr_type n;
      acc = 1'b0;
      if (cmd == CMD_PUSH) begin
         n = ptr_next(wr_ptr);
         if (n != rd_ptr) begin
            line_fifo[wr_ptr] = code;
            wr_ptr = n;
            acc = 1'b1;
            bytes_queued++;
         end else begin
            pushes_refused++;
         end
      end else begin
         case (seq)
            SEQ_IDLE: begin
               if (wr_ptr != rd_ptr) begin
                  shift_byte = line_fifo[rd_ptr];
                  rd_ptr = ptr_next(rd_ptr);
                  seq = SEQ_DATA;
                  frames_started++;
               end
            end
            SEQ_DATA: begin
               if (bit_idx == 0) begin
                  d = 1'b0;
                  par_acc = 1'b0;
               end else if (bit_idx <= DATA_LAST_BIT) begin
                  d = shift_byte[bit_idx - 1];
               end else if (bit_idx == PARITY_BIT) begin
                  d = ~par_acc;
               end else begin
                  d = 1'b1;
               end
               dat_lvl = d;
               par_acc = par_acc ^ d;
               bit_idx = bit_idx + 1'b1;
               if (bit_idx > FRAME_LAST_BIT) begin
                  bit_idx = '0;
                  seq = SEQ_IDLE;
               end else begin
                  seq = SEQ_CLK_LOW;
               end
            end
            SEQ_CLK_LOW: begin
               clk_lvl = 1'b0;
               seq = SEQ_CLK_HIGH;
            end
            default: begin
               clk_lvl = 1'b1;
               seq = SEQ_DATA;
            end
         endcase
      end
      r.clock_line    = clk_lvl;
      r.data_line     = dat_lvl;
      r.push_accepted = acc;
      r.sending       = (seq != SEQ_IDLE);
   endtask

   task automatic add_row(input command_type cmd, input byte_type code, input logic typed,
                          input logic clk, input logic dat, input logic acc,
                          input logic snd);
      stim_row_type row;
      row.cmd   = cmd;
      row.code  = code;
      row.typed = typed;
      row.rsp   = '{sending: snd, push_accepted: acc, data_line: dat, clock_line: clk};
      directed_rows.push_back(row);
   endtask

   // offer one item, hold until taken, then maybe go idle
   task automatic send_item(input command_type cmd, input byte_type code,
                            input logic typed, input line_rsp_type typed_rsp);
      line_rsp_type r;
      req_tvalid <= 1'b1;
      req_tdata  <= code;
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ps2_line_predict(cmd, code, r);
      expected_lines_q.push_back(typed ? typed_rsp : r);
      items_sent++;
      if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   task automatic wait_drained;
      while (expected_lines_q.size() != 0) @(posedge clock);
   endtask

   // receiver
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (no_idle) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         lines_checked++;
         if (expected_lines_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected item: tdata %h with nothing pending", rsp_tdata);
         end else begin
            line_exp = expected_lines_q.pop_front();
            if (rsp_tdata !== {4'b0000, line_exp}) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("item %0d: exp clk %b dat %b acc %b snd %b pad 0",
                           lines_checked, line_exp.clock_line, line_exp.data_line,
                           line_exp.push_accepted, line_exp.sending);
                  $display("item %0d: got clk %b dat %b acc %b snd %b pad %h",
                           lines_checked, rsp_tdata[0], rsp_tdata[1], rsp_tdata[2],
                           rsp_tdata[3], rsp_tdata[7:4]);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int push_pct;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_TICK;
      reset      = 1'b1;

      // idle and empty, byte extremes, fill to full, refused push, push mid-frame
      add_row(CMD_TICK, 8'h00, 1'b1, 1, 1, 0, 0);
      add_row(CMD_PUSH, 8'hFF, 1'b1, 1, 1, 1, 0);
      add_row(CMD_PUSH, 8'h00, 1'b1, 1, 1, 1, 0);
      for (int k = 0; k < FIFO_DEPTH - 3; k++)
         add_row(CMD_PUSH, byte_type'(8'h5A ^ (k * 8'h13)), 1'b0, 0, 0, 0, 0);
      add_row(CMD_PUSH, 8'hA5, 1'b1, 1, 1, 0, 0);
      add_row(CMD_TICK, 8'hFF, 1'b1, 1, 1, 0, 1);
      add_row(CMD_TICK, 8'h00, 1'b1, 1, 0, 0, 1);
      add_row(CMD_TICK, 8'h00, 1'b1, 0, 0, 0, 1);
      add_row(CMD_PUSH, 8'h3C, 1'b1, 0, 0, 1, 1);
      add_row(CMD_PUSH, 8'hC3, 1'b1, 0, 0, 0, 1);
      add_row(CMD_TICK, 8'h00, 1'b0, 0, 0, 0, 0);
      add_row(CMD_TICK, 8'h00, 1'b0, 0, 0, 0, 0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].cmd, directed_rows[i].code,
                   directed_rows[i].typed, directed_rows[i].rsp);

      push_pct = 5;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) begin
            case ($urandom_range(0, 2))
               0: push_pct = 2;
               1: push_pct = 6;
               default: push_pct = 20;
            endcase
         end
         no_idle = (i >= 500 && i < 700);
         if (i == 300)
            hold_off_req = 1'b1;
         if (i == 900) begin
            req_tvalid <= 1'b0;
            wait_drained();
         end
         if (i % 250 == 150) begin
            for (int k = 0; k < FIFO_DEPTH + 2; k++)
               send_item(CMD_PUSH, byte_type'($urandom_range(0, 255)), 1'b0, '0);
         end
         if ($urandom_range(0, 99) < push_pct)
            send_item(CMD_PUSH, byte_type'($urandom_range(0, 255)), 1'b0, '0);
         else
            send_item(CMD_TICK, byte_type'($urandom_range(0, 255)), 1'b0, '0);
      end

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d items: %0d bytes queued, %0d pushes refused at full,",
               items_sent, bytes_queued, pushes_refused);
      $display("%0d frames started, %0d results checked, %0d mismatches",
               frames_started, lines_checked, mismatches);
      if (mismatches == 0 && expected_lines_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
